[rtl/core/rdc_pkg.sv]
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;   // '0'
	localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'h41;   // 'A'
	localparam logic [CHAR_W-1:0]  CHAR_NONE  = 7'h00;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD_RADIX = 2'd2
	} status_t;

	// digit stack controls
	typedef struct packed {
		logic clear;
		logic push;
		logic rd_en;
	} stk_ctrl_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = {1'b0, d};
		if (d < DEC_DIGITS) begin
			return CHAR_ZERO + ext;
		end
		return CHAR_ALPHA + (ext - {1'b0, DEC_DIGITS});
	endfunction

endpackage

[rtl/core/rdc_in_if.sv]
// ----------------------------------------------------------------------------
// rdc_in_if
// Input channel: one integer and its target radix per beat.
// ----------------------------------------------------------------------------
interface rdc_in_if #(
	parameter int VALUE_BITS = 31
);
	logic                            valid;
	logic                            ready;
	logic [VALUE_BITS-1:0]           value;
	logic [rdc_pkg::RADIX_W-1:0]     radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink   (input valid, input value, input radix, output ready);
endinterface

[rtl/core/rdc_out_if.sv]
// ----------------------------------------------------------------------------
// rdc_out_if
// Output channel: one ASCII digit, last flag and status per beat.
// ----------------------------------------------------------------------------
interface rdc_out_if;
	logic                          valid;
	logic                          ready;
	logic [rdc_pkg::CHAR_W-1:0]    digit_char;
	logic                          last;
	logic [1:0]                    status;

	modport source (output valid, output digit_char, output last, output status, input ready);
	modport sink   (input valid, input digit_char, input last, input status, output ready);
endinterface

[rtl/core/rdc_divider.sv]
// ----------------------------------------------------------------------------
// rdc_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdc_divider #(
	parameter int VALUE_BITS = 31
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [VALUE_BITS-1:0]              dividend,
	input  logic [rdc_pkg::RADIX_W-1:0]        divisor,
	output logic                               done,
	output logic [VALUE_BITS-1:0]              quotient,
	output logic [rdc_pkg::DIGIT_W-1:0]        remainder
);
	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0]            q_q;
	logic [rdc_pkg::DIGIT_W-1:0]      r_q;
	logic [rdc_pkg::RADIX_W-1:0]      div_q;
	logic [CW-1:0]                    cnt_q;
	logic                             busy_q;
	logic                             done_q;

	logic [rdc_pkg::DIGIT_W:0]        trial;
	logic [rdc_pkg::DIGIT_W:0]        diff;
	logic                             ge;

	assign trial = {r_q, q_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(VALUE_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			r_q   <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[VALUE_BITS-2:0], ge};
			r_q <= ge ? diff[rdc_pkg::DIGIT_W-1:0] : trial[rdc_pkg::DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;
endmodule

[rtl/core/rdc_digit_stack.sv]
// ----------------------------------------------------------------------------
// rdc_digit_stack
// Digit buffer: digits pushed least significant first, read back by address.
// ----------------------------------------------------------------------------
module rdc_digit_stack #(
	parameter int MAX_DIGITS = 31
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rdc_pkg::stk_ctrl_t                     ctrl,
	input  logic [rdc_pkg::DIGIT_W-1:0]            wdata,
	input  logic [$clog2(MAX_DIGITS)-1:0]          raddr,
	output logic [rdc_pkg::DIGIT_W-1:0]            rdata,
	output logic [$clog2(MAX_DIGITS+1)-1:0]        count
);
	localparam int AW   = $clog2(MAX_DIGITS);
	localparam int CNTW = $clog2(MAX_DIGITS + 1);

	logic [rdc_pkg::DIGIT_W-1:0] digit_buffer [MAX_DIGITS];
	logic [CNTW-1:0]             count_q;
	logic [rdc_pkg::DIGIT_W-1:0] rdata_q;
	logic                        room;

	assign room = count_q < CNTW'(MAX_DIGITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.push && room) begin
			count_q <= count_q + 1'b1;
		end
	end

	// higher digits beyond capacity are dropped
	always_ff @(posedge clk) begin
		if (ctrl.push && room && !ctrl.clear) begin
			digit_buffer[count_q[AW-1:0]] <= wdata;
		end
		if (ctrl.rd_en) begin
			rdata_q <= digit_buffer[raddr];
		end
	end

	assign rdata = rdata_q;
	assign count = count_q;
endmodule

[rtl/core/radix_digit_converter.sv]
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a non-negative integer to ASCII digits in radix 2..36, MSD first.
// ----------------------------------------------------------------------------
// Usage:
//  - number channel: one beat carries value and radix. It is taken only while
//    the converter is idle; one input is handled at a time.
//  - digits channel: one beat per digit, most significant first, last set on
//    the final one. A zero value gives one beat with status empty; a radix
//    outside 2..36 gives one beat with status bad radix, digit_char 0.
//  - Each digit costs one bit-serial division on the shared divider (one
//    quotient bit per cycle). Readout then does a buffer read and an output
//    load for each digit; the load waits while the output beat is not taken.
//  - Only the MAX_DIGITS least significant digits are kept.
//  - A finished beat waits in the output register; a stalled receiver holds
//    the converter in readout, nothing is dropped.
//  - Reset clears control state and the output register only; the digit buffer needs no clearing.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
	parameter int VALUE_BITS = 31,
	parameter int MAX_DIGITS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	rdc_in_if.sink      number,
	rdc_out_if.source   digits
);
	localparam int AW   = $clog2(MAX_DIGITS);
	localparam int CNTW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FLAG,   // special case, single flagged beat
		S_DIV,    // divider running
		S_READ,   // buffer read issued
		S_EMIT    // load digit into output register
	} state_t;

	state_t                          state_q;
	rdc_pkg::status_t                flag_q;
	logic [rdc_pkg::RADIX_W-1:0]     radix_q;
	logic [AW-1:0]                   rd_ptr_q;

	// output register
	logic                            out_valid_q;
	logic [rdc_pkg::CHAR_W-1:0]      out_char_q;
	logic                            out_last_q;
	rdc_pkg::status_t                out_status_q;

	logic                            in_fire;
	logic                            val_zero;
	logic                            radix_bad;
	logic                            out_free;

	// divider hookup
	logic                            div_start;
	logic [VALUE_BITS-1:0]           div_dividend;
	logic [rdc_pkg::RADIX_W-1:0]     div_divisor;
	logic                            div_done;
	logic [VALUE_BITS-1:0]           div_quot;
	logic [rdc_pkg::DIGIT_W-1:0]     div_rem;
	logic                            quot_zero;

	// digit stack hookup
	rdc_pkg::stk_ctrl_t              stk_ctrl;
	logic [rdc_pkg::DIGIT_W-1:0]     stk_rdata;
	logic [CNTW-1:0]                 stk_count;
	logic [AW-1:0]                   top_idx;

	assign number.ready = (state_q == S_IDLE);
	assign in_fire      = number.valid && number.ready;
	assign val_zero     = (number.value == '0);
	assign radix_bad    = (number.radix < rdc_pkg::RADIX_MIN) ||
	                      (number.radix > rdc_pkg::RADIX_MAX);
	assign out_free     = !out_valid_q || digits.ready;
	assign quot_zero    = (div_quot == '0);

	// first division from the input beat, later ones from the last quotient
	assign div_start    = (in_fire && !val_zero && !radix_bad) ||
	                      (state_q == S_DIV && div_done && !quot_zero);
	assign div_dividend = (state_q == S_IDLE) ? number.value : div_quot;
	assign div_divisor  = (state_q == S_IDLE) ? number.radix : radix_q;

	assign stk_ctrl.clear = in_fire;
	assign stk_ctrl.push  = (state_q == S_DIV) && div_done;
	assign stk_ctrl.rd_en = (state_q == S_READ);

	// index of the most significant digit once this push lands
	assign top_idx = (stk_count == CNTW'(MAX_DIGITS)) ? AW'(MAX_DIGITS - 1)
	                                                 : stk_count[AW-1:0];

	rdc_divider #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	rdc_digit_stack #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (stk_ctrl),
		.wdata  (div_rem),
		.raddr  (rd_ptr_q),
		.rdata  (stk_rdata),
		.count  (stk_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			flag_q       <= rdc_pkg::ST_OK;
			radix_q      <= '0;
			rd_ptr_q     <= '0;
			out_valid_q  <= 1'b0;
			out_char_q   <= rdc_pkg::CHAR_NONE;
			out_last_q   <= 1'b0;
			out_status_q <= rdc_pkg::ST_OK;
		end else begin
			if (out_valid_q && digits.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						radix_q <= number.radix;
						if (val_zero) begin
							flag_q  <= rdc_pkg::ST_EMPTY;
							state_q <= S_FLAG;
						end else if (radix_bad) begin
							flag_q  <= rdc_pkg::ST_BAD_RADIX;
							state_q <= S_FLAG;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_FLAG: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_char_q   <= rdc_pkg::CHAR_NONE;
						out_last_q   <= 1'b1;
						out_status_q <= flag_q;
						state_q      <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done && quot_zero) begin
						rd_ptr_q <= top_idx;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_char_q   <= rdc_pkg::digit_to_ascii(stk_rdata);
						out_last_q   <= (rd_ptr_q == '0);
						out_status_q <= rdc_pkg::ST_OK;
						if (rd_ptr_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q - 1'b1;
							state_q  <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign digits.valid      = out_valid_q;
	assign digits.digit_char = out_char_q;
	assign digits.last       = out_last_q;
	assign digits.status     = out_status_q;
endmodule

[test/rdc_digit_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdc_digit_checker
// Watches both channels of the radix digit converter, predicts the digit
// beats of every accepted number and compares them in order as they leave.
// ----------------------------------------------------------------------------
module rdc_digit_checker #(
	parameter int VALUE_BITS = 31,
	parameter int MAX_DIGITS = 31
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        number_valid,
	input  logic                        number_ready,
	input  logic [VALUE_BITS-1:0]       number_value,
	input  logic [rdc_pkg::RADIX_W-1:0] number_radix,
	input  logic                        digits_valid,
	input  logic                        digits_ready,
	input  logic [rdc_pkg::CHAR_W-1:0]  digit_char,
	input  logic                        last,
	input  logic [1:0]                  status,
	output int                          mismatches,
	output int                          outstanding
);
	localparam int CHAR_W  = rdc_pkg::CHAR_W;
	localparam int DIGIT_W = rdc_pkg::DIGIT_W;
	localparam int RADIX_W = rdc_pkg::RADIX_W;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
		rdc_pkg::status_t  status;
	} digit_beat_t;

	digit_beat_t expected_digits [$];
	int          fail_total = 0;

	// Expected digit beats of one number, most significant digit first.
	function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
			input logic [RADIX_W-1:0] radix);
		logic [VALUE_BITS-1:0] quotient;
		logic [DIGIT_W-1:0]    lsd_first [$];
		logic [DIGIT_W-1:0]    d;
		digit_beat_t           beat;
		if (value == '0) begin
			beat = '{rdc_pkg::CHAR_NONE, 1'b1, rdc_pkg::ST_EMPTY};
			expected_digits.push_back(beat);
			return;
		end
		if (radix < rdc_pkg::RADIX_MIN || radix > rdc_pkg::RADIX_MAX) begin
			beat = '{rdc_pkg::CHAR_NONE, 1'b1, rdc_pkg::ST_BAD_RADIX};
			expected_digits.push_back(beat);
			return;
		end
		quotient = value;
		while (quotient != '0) begin
			// only the least significant digits fit in the buffer
			if (lsd_first.size() < MAX_DIGITS)
				lsd_first.push_back(DIGIT_W'(quotient % radix));
			quotient = quotient / radix;
		end
		for (int k = lsd_first.size() - 1; k >= 0; k--) begin
			d = lsd_first[k];
			if (d < 10)
				beat.digit_char = rdc_pkg::CHAR_ZERO + CHAR_W'(d);
			else
				beat.digit_char = rdc_pkg::CHAR_ALPHA + CHAR_W'(d) - CHAR_W'(10);
			beat.last   = (k == 0);
			beat.status = rdc_pkg::ST_OK;
			expected_digits.push_back(beat);
		end
	endfunction

	task automatic note_failure(input string what);
		fail_total++;
		if (fail_total <= 10)
			$display("%0t ns: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		digit_beat_t want;
		if (arst_n) begin
			if (number_valid && number_ready)
				predict_digits(number_value, number_radix);
			if (digits_valid && digits_ready) begin
				if (expected_digits.size() == 0) begin
					note_failure($sformatf("unexpected beat: char %0d last %0b status %0d",
						digit_char, last, status));
				end else begin
					want = expected_digits.pop_front();
					if (digit_char !== want.digit_char || last !== want.last ||
							status !== want.status)
						note_failure($sformatf({"digit mismatch: expected char %0d last %0b",
							" status %0d, got char %0d last %0b status %0d"},
							want.digit_char, want.last, want.status,
							digit_char, last, status));
				end
			end
		end
		mismatches  <= fail_total;
		outstanding <= expected_digits.size();
	end

endmodule

[test/tb_radix_digit_converter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_digit_converter
// Drives numbers and radixes into the converter with random gaps and random
// backpressure on the digit side; a checker beside the block predicts every
// digit beat and counts mismatches. Directed corner cases come first, then
// randomly sized numbers over valid and invalid radixes.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter;

	localparam int VALUE_BITS     = 31;
	localparam int MAX_DIGITS     = 31;
	localparam int RADIX_W        = rdc_pkg::RADIX_W;
	localparam int RANDOM_NUMBERS = 420;
	// longest quiet stretch in a correct run is one 31-digit conversion
	// plus a long gap; allow plenty of margin
	localparam int WATCHDOG_LIMIT = 8000;
	// drain time after the last expected beat, to catch stray extra beats
	localparam int TAIL_CYCLES    = 64;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   quiet_cycles = 0;
	int   input_burst  = 0;   // beats left to send back to back
	int   ready_hold   = 0;   // cycles left with ready low
	int   ready_steady = 0;   // cycles left with ready forced high

	rdc_in_if #(.VALUE_BITS(VALUE_BITS)) number_ch ();
	rdc_out_if                           digits_ch ();

	radix_digit_converter #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.number(number_ch),
		.digits(digits_ch)
	);

	rdc_digit_checker #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_valid(number_ch.valid),
		.number_ready(number_ch.ready),
		.number_value(number_ch.value),
		.number_radix(number_ch.radix),
		.digits_valid(digits_ch.valid),
		.digits_ready(digits_ch.ready),
		.digit_char  (digits_ch.digit_char),
		.last        (digits_ch.last),
		.status      (digits_ch.status),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Offer one number beat and hold it until the converter takes it. Valid
	// stays high across back-to-back beats, so it only drops for a real gap.
	task automatic send_number(input logic [VALUE_BITS-1:0] value,
			input logic [RADIX_W-1:0] radix);
		int gap;
		gap = (input_burst > 0) ? 0 : pick_gap();
		if (input_burst > 0)
			input_burst--;
		else if ($urandom_range(0, 40) == 0)
			input_burst = $urandom_range(10, 30);
		if (gap > 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.value <= value;
		number_ch.radix <= radix;
		do
			@(posedge clk);
		while (!(number_ch.valid && number_ch.ready));
	endtask

	// Random number: random bit length so short and long digit strings both
	// show up, a few zeros, and about one in ten with an invalid radix.
	task automatic send_random_number();
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_W-1:0]    radix;
		int                    roll;
		int                    width;
		roll  = $urandom_range(0, 99);
		width = $urandom_range(1, VALUE_BITS);
		value = VALUE_BITS'($urandom & ((32'h1 << width) - 32'h1));
		if (roll < 5)
			value = '0;
		if (roll >= 5 && roll < 15)
			radix = ($urandom_range(0, 2) == 0) ? RADIX_W'($urandom_range(0, 1))
				: RADIX_W'($urandom_range(37, 63));
		else
			radix = RADIX_W'($urandom_range(rdc_pkg::RADIX_MIN, rdc_pkg::RADIX_MAX));
		send_number(value, radix);
	endtask

	// Digit-side backpressure: random stalls with stall-free stretches.
	always @(posedge clk) begin
		if (!arst_n) begin
			digits_ch.ready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold--;
			digits_ch.ready <= 1'b0;
		end else begin
			digits_ch.ready <= 1'b1;
			if (ready_steady > 0)
				ready_steady--;
			else if ($urandom_range(0, 63) == 0)
				ready_steady = $urandom_range(50, 200);
			else if ($urandom_range(0, 3) == 0)
				ready_hold = pick_gap();
		end
	end

	// Watchdog: counts cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((number_ch.valid && number_ch.ready) || (digits_ch.valid && digits_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n          <= 1'b0;
		number_ch.valid <= 1'b0;
		number_ch.value <= '0;
		number_ch.radix <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero value wins over any radix check
		send_number('0, 6'd0);
		send_number('0, 6'd10);
		send_number('0, 6'd63);
		// invalid radixes with a nonzero value
		send_number(31'd5, 6'd0);
		send_number(31'd5, 6'd1);
		send_number(31'd5, 6'd37);
		send_number(31'd5, 6'd63);
		// smallest value, edge radixes
		send_number(31'd1, rdc_pkg::RADIX_MIN);
		send_number(31'd1, rdc_pkg::RADIX_MAX);
		// full-scale value: 31 binary digits fills the buffer exactly
		send_number('1, rdc_pkg::RADIX_MIN);
		send_number('1, rdc_pkg::RADIX_MAX);
		send_number('1, 6'd35);
		send_number('1, 6'd10);
		send_number('1, 6'd16);
		send_number(31'h4000_0000, rdc_pkg::RADIX_MIN);
		// digit-to-letter boundary: '9', 'A', 'Z', and a carry into "10"
		send_number(31'd9, 6'd10);
		send_number(31'd10, 6'd11);
		send_number(31'd35, rdc_pkg::RADIX_MAX);
		send_number(31'd36, rdc_pkg::RADIX_MAX);
		send_number(31'd255, 6'd16);
		send_number(31'd100, 6'd3);
		send_number(31'd12345, 6'd7);

		repeat (RANDOM_NUMBERS) send_random_number();
		number_ch.valid <= 1'b0;

		// drain: the checker's count is registered, so look after an edge
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[radix_digit_converter.f]
rtl/core/rdc_pkg.sv
rtl/core/rdc_in_if.sv
rtl/core/rdc_out_if.sv
rtl/core/rdc_divider.sv
rtl/core/rdc_digit_stack.sv
rtl/core/radix_digit_converter.sv
test/rdc_digit_checker.sv
test/tb_radix_digit_converter.sv
